// ===== rtl/rmq_pkg.sv =====
// Shared types, widths and constants of the rotation-matrix-to-quaternion core.
package rmq_pkg;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned FIELD_W   = 16;

  // trace-like sums, signed
  localparam int unsigned T_W     = FIELD_W + 2;
  // first square root: radicand rounded up to an even width
  localparam int unsigned RAD_A_W = ((T_W - 1 + FRAC_BITS + 1) / 2) * 2;
  localparam int unsigned R_W     = RAD_A_W / 2;
  localparam int unsigned SQ_W    = 2 * R_W;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned L_W     = SUM_W / 2;
  // normalizing divide
  localparam int unsigned NUM_W   = R_W + FRAC_BITS + 2;
  localparam int unsigned DEN_W   = L_W + 1;
  localparam int unsigned Q_W     = FRAC_BITS + 2;

  localparam int unsigned LANES   = 4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m00;
    logic signed [FIELD_W-1:0] m01;
    logic signed [FIELD_W-1:0] m02;
    logic signed [FIELD_W-1:0] m10;
    logic signed [FIELD_W-1:0] m11;
    logic signed [FIELD_W-1:0] m12;
    logic signed [FIELD_W-1:0] m20;
    logic signed [FIELD_W-1:0] m21;
    logic signed [FIELD_W-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quat_w;
    logic signed [FIELD_W-1:0] quat_x;
    logic signed [FIELD_W-1:0] quat_y;
    logic signed [FIELD_W-1:0] quat_z;
  } quat_t;

endpackage

// ===== rtl/rmq_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage, several lanes in step.
module rmq_sqrt_pipe #(
  parameter int unsigned IN_W   = 32,
  parameter int unsigned LANES  = 1,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [IN_W-1:0]      rad_i [LANES],
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [IN_W/2-1:0]    root_o [LANES],
  output logic [SIDE_W-1:0]    side_o
);
  localparam int unsigned OUT_W = IN_W / 2;
  localparam int unsigned REM_W = OUT_W + 2;

  logic              vld_s  [1:OUT_W];
  logic [SIDE_W-1:0] side_s [1:OUT_W];
  logic [IN_W-1:0]   rad_s  [1:OUT_W][LANES];
  logic [REM_W-1:0]  rem_s  [1:OUT_W][LANES];
  logic [OUT_W-1:0]  root_s [1:OUT_W][LANES];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic              cur_vld;
    logic [SIDE_W-1:0] cur_side;

    if (k == 0) begin : g_first
      assign cur_vld  = valid_i;
      assign cur_side = side_i;
    end else begin : g_next
      assign cur_vld  = vld_s[k];
      assign cur_side = side_s[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      side_s[k+1] <= cur_side;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [IN_W-1:0]  cur_rad;
      logic [REM_W-1:0] cur_rem;
      logic [OUT_W-1:0] cur_root;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;

      if (k == 0) begin : g_first
        assign cur_rad  = rad_i[l];
        assign cur_rem  = '0;
        assign cur_root = '0;
      end else begin : g_next
        assign cur_rad  = rad_s[k][l];
        assign cur_rem  = rem_s[k][l];
        assign cur_root = root_s[k][l];
      end

      // bring down the next two radicand bits, try root*4+1
      assign rem_sh = {cur_rem[REM_W-3:0], cur_rad[IN_W-1 -: 2]};
      assign trial  = {cur_root, 2'b01};

      always_ff @(posedge clk_i) begin
        rad_s[k+1][l] <= cur_rad << 2;
        if (rem_sh >= trial) begin
          rem_s[k+1][l]  <= rem_sh - trial;
          root_s[k+1][l] <= {cur_root[OUT_W-2:0], 1'b1};
        end else begin
          rem_s[k+1][l]  <= rem_sh;
          root_s[k+1][l] <= {cur_root[OUT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_s[OUT_W];
  assign side_o  = side_s[OUT_W];
  assign root_o  = root_s[OUT_W];

endmodule

// ===== rtl/rmq_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
module rmq_div_pipe #(
  parameter int unsigned NUM_W  = 32,
  parameter int unsigned DEN_W  = 18,
  parameter int unsigned Q_W    = 16,
  parameter int unsigned LANES  = 4,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i [LANES],
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o [LANES],
  output logic [SIDE_W-1:0] side_o
);
  localparam int unsigned W = DEN_W + Q_W;

  logic              vld_s  [1:Q_W];
  logic [SIDE_W-1:0] side_s [1:Q_W];
  logic [DEN_W-1:0]  den_s  [1:Q_W];
  logic [NUM_W-1:0]  rem_s  [1:Q_W][LANES];
  logic [Q_W-1:0]    quo_s  [1:Q_W][LANES];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              cur_vld;
    logic [SIDE_W-1:0] cur_side;
    logic [DEN_W-1:0]  cur_den;
    logic [W-1:0]      dsh;

    if (k == 0) begin : g_first
      assign cur_vld  = valid_i;
      assign cur_side = side_i;
      assign cur_den  = den_i;
    end else begin : g_next
      assign cur_vld  = vld_s[k];
      assign cur_side = side_s[k];
      assign cur_den  = den_s[k];
    end

    // divisor aligned to quotient bit Q_W-1-k
    assign dsh = {cur_den, {Q_W{1'b0}}} >> (k + 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else begin
        vld_s[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      side_s[k+1] <= cur_side;
      den_s[k+1]  <= cur_den;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [NUM_W-1:0] cur_rem;
      logic [Q_W-1:0]   cur_quo;
      logic [W-1:0]     rem_x;
      logic             ge;

      if (k == 0) begin : g_first
        assign cur_rem = num_i[l];
        assign cur_quo = '0;
      end else begin : g_next
        assign cur_rem = rem_s[k][l];
        assign cur_quo = quo_s[k][l];
      end

      assign rem_x = W'(cur_rem);
      assign ge    = (rem_x >= dsh);

      always_ff @(posedge clk_i) begin
        rem_s[k+1][l] <= ge ? NUM_W'(rem_x - dsh) : cur_rem;
        quo_s[k+1][l] <= {cur_quo[Q_W-2:0], ge};
      end
    end
  end

  assign valid_o = vld_s[Q_W];
  assign side_o  = side_s[Q_W];
  assign quo_o   = quo_s[Q_W];

endmodule

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// Top level: rotation matrix (Q1.14) to unit quaternion, fully pipelined.
//
// One matrix is taken on every clock at which start is high; busy stays low,
// so the core never refuses a transfer. Each matrix produces exactly one
// quaternion, shown on quat_o for one cycle with done_o high. The receiver
// cannot stall the core, so results must be taken when shown.
// The path runs through the two bit-serial square-root pipelines (16 and 17
// stages, one root bit each) and the 16-stage normalizing divider, plus
// input, radicand, square, two adder-tree, numerator and output registers.
// Components are the four trace sums clamped at zero, square-rooted, and
// divided by the quaternion length with round half up; x, y, z take their
// signs from the off-diagonal differences (zero counts as positive). Results
// saturate to +-1.0. Entries outside +-1.0 are processed by the same
// arithmetic.
module rotation_matrix_to_quaternion_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rmq_pkg::matrix_t mat_i,
  output logic            done_o,
  output rmq_pkg::quat_t  quat_o
);
  import rmq_pkg::*;

  localparam int unsigned LAT  = 2 + R_W + 1 + 2 + L_W + 1 + Q_W + 1;
  localparam int unsigned SB_W = LANES * R_W + 3;
  localparam logic signed [T_W-1:0] QONE_T = T_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] QONE_Q = Q_W'(1) << FRAC_BITS;

  assign busy = 1'b0;

  // input register
  logic    in_vld_q;
  matrix_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= mat_i;
  end

  // trace sums, clamp, radicands, signs
  logic signed [T_W-1:0]   a_s, b_s, c_s;
  logic signed [T_W-1:0]   t_d [LANES];
  logic [FIELD_W:0]        dx, dy, dz;
  logic                    rad_vld_q;
  logic [RAD_A_W-1:0]      rad_q [LANES];
  logic [2:0]              neg_q;

  assign a_s = T_W'(in_q.m00);
  assign b_s = T_W'(in_q.m11);
  assign c_s = T_W'(in_q.m22);

  assign t_d[0] = QONE_T + a_s + b_s + c_s;
  assign t_d[1] = QONE_T + a_s - b_s - c_s;
  assign t_d[2] = QONE_T - a_s + b_s - c_s;
  assign t_d[3] = QONE_T - a_s - b_s + c_s;

  assign dx = (FIELD_W+1)'(in_q.m21) - (FIELD_W+1)'(in_q.m12);
  assign dy = (FIELD_W+1)'(in_q.m02) - (FIELD_W+1)'(in_q.m20);
  assign dz = (FIELD_W+1)'(in_q.m10) - (FIELD_W+1)'(in_q.m01);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_vld_q <= 1'b0;
    end else begin
      rad_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      rad_q[l] <= t_d[l][T_W-1] ? '0
                : RAD_A_W'({t_d[l][T_W-2:0], {FRAC_BITS{1'b0}}});
    end
    neg_q <= {dz[FIELD_W], dy[FIELD_W], dx[FIELD_W]};
  end

  // component magnitudes before normalizing
  logic             ra_vld;
  logic [R_W-1:0]   ra_root [LANES];
  logic [2:0]       ra_neg;

  rmq_sqrt_pipe #(
    .IN_W  (RAD_A_W),
    .LANES (LANES),
    .SIDE_W(3)
  ) u_sqrt_comp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(rad_vld_q),
    .rad_i  (rad_q),
    .side_i (neg_q),
    .valid_o(ra_vld),
    .root_o (ra_root),
    .side_o (ra_neg)
  );

  // squares
  logic           sq_vld_q;
  logic [SQ_W-1:0] sq_q [LANES];
  logic [R_W-1:0] r1_q [LANES];
  logic [2:0]     neg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= ra_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      sq_q[l] <= ra_root[l] * ra_root[l];
    end
    r1_q   <= ra_root;
    neg1_q <= ra_neg;
  end

  // adder tree, two levels
  logic             p_vld_q, s_vld_q;
  logic [SQ_W:0]    p0_q, p1_q;
  logic [SUM_W-1:0] s_q;
  logic [R_W-1:0]   r2_q [LANES];
  logic [R_W-1:0]   r3_q [LANES];
  logic [2:0]       neg2_q, neg3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else begin
      p_vld_q <= sq_vld_q;
      s_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q   <= (SQ_W+1)'(sq_q[0]) + (SQ_W+1)'(sq_q[1]);
    p1_q   <= (SQ_W+1)'(sq_q[2]) + (SQ_W+1)'(sq_q[3]);
    s_q    <= SUM_W'(p0_q) + SUM_W'(p1_q);
    r2_q   <= r1_q;
    r3_q   <= r2_q;
    neg2_q <= neg1_q;
    neg3_q <= neg2_q;
  end

  // quaternion length, magnitudes and signs ride along
  logic [SUM_W-1:0] s_arr [1];
  logic [L_W-1:0]   len_arr [1];
  logic [SB_W-1:0]  sb_in, sb_out;
  logic             len_vld;
  logic [R_W-1:0]   r4 [LANES];
  logic [2:0]       neg4;

  assign s_arr[0] = s_q;
  assign sb_in    = {neg3_q, r3_q[3], r3_q[2], r3_q[1], r3_q[0]};

  rmq_sqrt_pipe #(
    .IN_W  (SUM_W),
    .LANES (1),
    .SIDE_W(SB_W)
  ) u_sqrt_len (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_vld_q),
    .rad_i  (s_arr),
    .side_i (sb_in),
    .valid_o(len_vld),
    .root_o (len_arr),
    .side_o (sb_out)
  );

  assign {neg4, r4[3], r4[2], r4[1], r4[0]} = sb_out;

  // numerators (2*r<<F + L) and divisor 2*L
  logic             nd_vld_q;
  logic [NUM_W-1:0] num_q [LANES];
  logic [DEN_W-1:0] den_q;
  logic [3:0]       nd_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_vld_q <= 1'b0;
    end else begin
      nd_vld_q <= len_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      num_q[l] <= NUM_W'({r4[l], {(FRAC_BITS + 1){1'b0}}}) + NUM_W'(len_arr[0]);
    end
    den_q     <= {len_arr[0], 1'b0};
    nd_side_q <= {neg4, len_arr[0] == '0};
  end

  logic           dv_vld;
  logic [Q_W-1:0] quo [LANES];
  logic [3:0]     dv_side;

  rmq_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (Q_W),
    .LANES (LANES),
    .SIDE_W(4)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(nd_vld_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .side_i (nd_side_q),
    .valid_o(dv_vld),
    .quo_o  (quo),
    .side_o (dv_side)
  );

  // sign, saturate, output register
  logic [Q_W-1:0]     mag [LANES];
  logic [LANES-1:0]   neg_l;
  logic [FIELD_W-1:0] res_d [LANES];
  logic               done_q;
  quat_t              quat_q;

  // zero length only when every magnitude is zero
  assign neg_l = {dv_side[3:1], 1'b0};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = dv_side[0] ? '0 : ((quo[l] > QONE_Q) ? QONE_Q : quo[l]);
      res_d[l] = neg_l[l] ? FIELD_W'(-mag[l]) : FIELD_W'(mag[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    quat_q.quat_w <= res_d[0];
    quat_q.quat_x <= res_d[1];
    quat_q.quat_y <= res_d[2];
    quat_q.quat_z <= res_d[3];
  end

  assign done_o = done_q;
  assign quat_o = quat_q;

  // every result traces back to an earlier start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without matching start");

  // scalar part is never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !quat_o.quat_w[FIELD_W-1])
    else $error("negative scalar part");

  // x component stays within +-1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (quat_o.quat_x <= $signed(FIELD_W'(QONE_Q)))
            && (quat_o.quat_x >= -$signed(FIELD_W'(QONE_Q))))
    else $error("x component out of range");

endmodule

// ===== tb/tb_rotation_matrix_to_quaternion_core.sv =====
// Testbench for the rotation-matrix-to-quaternion core: directed and random matrices checked against a local predictor.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_core;
  import rmq_pkg::*;

  localparam int unsigned LATENCY   = 56;
  localparam int unsigned MAX_CYCLE = 400000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  matrix_t mat_i = '0;
  logic    done_o;
  quat_t   quat_o;

  matrix_t pending_mats[$];
  quat_t   expected_quats[$];
  int      send_idle_pct = 28;
  int      errors = 0;
  int      cycle_cnt = 0;

  rotation_matrix_to_quaternion_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .mat_i (mat_i),
    .done_o(done_o),
    .quat_o(quat_o)
  );

  always #5 clk_i = ~clk_i;

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp_unit(longint v);
    longint one;
    one = longint'(1) << FRAC_BITS;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[FIELD_W-1:0];
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t m);
    longint          a, b, c, one, v;
    longint          t[4];
    bit              neg[4];
    longint unsigned r[4];
    longint unsigned s, len, mag;
    logic signed [FIELD_W-1:0] q[4];
    quat_t           res;
    one = longint'(1) << FRAC_BITS;
    a = m.m00; b = m.m11; c = m.m22;
    t[0] = one + a + b + c;
    t[1] = one + a - b - c;
    t[2] = one - a + b - c;
    t[3] = one - a - b + c;
    neg[0] = 1'b0;
    // zero difference counts as positive
    neg[1] = (longint'(m.m21) - longint'(m.m12)) < 0;
    neg[2] = (longint'(m.m02) - longint'(m.m20)) < 0;
    neg[3] = (longint'(m.m10) - longint'(m.m01)) < 0;
    s = 0;
    for (int k = 0; k < 4; k++) begin
      r[k] = int_sqrt((t[k] > 0 ? longint'(t[k]) : 0) << FRAC_BITS);
      s += r[k] * r[k];
    end
    len = int_sqrt(s);
    for (int k = 0; k < 4; k++) begin
      if (len != 0) mag = (((r[k] << FRAC_BITS) * 2) + len) / (2 * len);
      else mag = r[k] >> 1;
      v = longint'(mag);
      if (neg[k]) v = -v;
      q[k] = clamp_unit(v);
    end
    res.quat_w = q[0]; res.quat_x = q[1]; res.quat_y = q[2]; res.quat_z = q[3];
    return res;
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_entry();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      4: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // driver: new transfer only when the current one has been taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!start || !busy) begin
        if (pending_mats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          mat_i <= pending_mats.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // predictor on accepted inputs, checker on strobed results
  always @(posedge clk_i) begin
    quat_t exp_q;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && start && !busy) expected_quats.push_back(matrix_to_quat(mat_i));
    if (rst_ni && done_o) begin
      if (expected_quats.size() == 0) begin
        $error("result with no transfer pending");
        errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (quat_o.quat_w !== exp_q.quat_w) begin
          $error("quat_w expected %0d actual %0d", exp_q.quat_w, quat_o.quat_w); errors++;
        end
        if (quat_o.quat_x !== exp_q.quat_x) begin
          $error("quat_x expected %0d actual %0d", exp_q.quat_x, quat_o.quat_x); errors++;
        end
        if (quat_o.quat_y !== exp_q.quat_y) begin
          $error("quat_y expected %0d actual %0d", exp_q.quat_y, quat_o.quat_y); errors++;
        end
        if (quat_o.quat_z !== exp_q.quat_z) begin
          $error("quat_z expected %0d actual %0d", exp_q.quat_z, quat_o.quat_z); errors++;
        end
      end
    end
    if (cycle_cnt > MAX_CYCLE) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    matrix_t m;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: identity, 180- and 90-degree turns, zero matrix, extremes, sign ties
    m = '0; m.m00 = 16384; m.m11 = 16384; m.m22 = 16384; pending_mats.push_back(m);
    m = '0; m.m00 = 16384; m.m11 = -16384; m.m22 = -16384; pending_mats.push_back(m);
    m = '0; m.m00 = -16384; m.m11 = 16384; m.m22 = -16384; pending_mats.push_back(m);
    m = '0; m.m00 = -16384; m.m11 = -16384; m.m22 = 16384; pending_mats.push_back(m);
    m = '0; pending_mats.push_back(m);
    m = {9{16'sd16384}}; pending_mats.push_back(m);
    m = {9{-16'sd16384}}; pending_mats.push_back(m);
    m = {9{16'sd32767}}; pending_mats.push_back(m);
    m = {9{-16'sd32768}}; pending_mats.push_back(m);
    m = {9{16'hAAAA}}; pending_mats.push_back(m);
    m = {9{16'h5555}}; pending_mats.push_back(m);
    m = '0; m.m00 = 16384; m.m12 = -16384; m.m21 = 16384; pending_mats.push_back(m);
    m = '0; m.m00 = 16384; m.m12 = 16384; m.m21 = -16384; pending_mats.push_back(m);
    m = '0; m.m22 = 16384; m.m01 = 16384; m.m10 = -16384; pending_mats.push_back(m);
    m = '0; m.m11 = 16384; m.m02 = -16384; m.m20 = 16384; pending_mats.push_back(m);
    for (int i = 0; i < 2000; i++) begin
      m.m00 = rand_entry(); m.m01 = rand_entry(); m.m02 = rand_entry();
      m.m10 = rand_entry(); m.m11 = rand_entry(); m.m12 = rand_entry();
      m.m20 = rand_entry(); m.m21 = rand_entry(); m.m22 = rand_entry();
      pending_mats.push_back(m);
      // idling phases follow the queue depth
      if (i == 700) wait (pending_mats.size() < 20);
      if (i == 700) send_idle_pct = 63;
      if (i == 1400) wait (pending_mats.size() < 20);
      if (i == 1400) send_idle_pct = 0;
    end
    wait (pending_mats.size() == 0 && !start);
    wait (expected_quats.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
